// ===== hdl/he_pkg.sv =====
`default_nettype none

package he_pkg;

  localparam int HE_NUM_BINS   = 256;
  localparam int HE_COUNT_BITS = 21;
  localparam int HE_FRAC_BITS  = 8;

  localparam int HE_LUMA_W    = 16;
  localparam int HE_LUMA_FRAC = 4;
  localparam int HE_OUT_W     = 16;

  localparam int HE_OPQ_DEPTH = 4;
  localparam int HE_RESQ_DEPTH = 2;

  typedef struct packed {
    logic                        func;
    logic signed [HE_LUMA_W-1:0] luma;
    logic                        last;
  } in_item_t;

  typedef struct packed {
    logic [HE_OUT_W-1:0] equalized;
    logic                no_table;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_COUNT_LAST,
    OP_MAP
  } op_kind_t;

endpackage

`default_nettype wire

// ===== hdl/he_fifo.sv =====
`default_nettype none

module he_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push_ok, pop_ok;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/he_front.sv =====
`default_nettype none

module he_front
  import he_pkg::*;
#(
  parameter int NUM_BINS = HE_NUM_BINS,
  parameter int DEPTH    = HE_OPQ_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire in_item_t                    item,
  output logic                             full,
  output logic                             op_valid,
  output op_kind_t                         op_kind,
  output logic [$clog2(NUM_BINS)-1:0]      op_bin,
  input  wire logic                        op_pop
);

  localparam int BB     = $clog2(NUM_BINS);
  localparam int KW     = $bits(op_kind_t);
  localparam int OW     = KW + BB;
  localparam int IP_W   = HE_LUMA_W - HE_LUMA_FRAC;
  localparam logic [IP_W:0] BIN_MAX = (IP_W + 1)'(NUM_BINS - 1);

  logic [IP_W-1:0] int_part;
  logic [BB-1:0]   bin;
  op_kind_t        kind;
  logic [OW-1:0]   q_wdata, q_rdata;
  logic            q_empty;

  // clamp to the bin range: negatives to bin 0, large values to the top bin
  always_comb begin
    int_part = item.luma[HE_LUMA_W-1:HE_LUMA_FRAC];
    if (item.luma[HE_LUMA_W-1]) begin
      bin = '0;
    end else if ({1'b0, int_part} > BIN_MAX) begin
      bin = BB'(NUM_BINS - 1);
    end else begin
      bin = BB'(int_part);
    end
  end

  always_comb begin
    if (item.func) begin
      kind = OP_MAP;
    end else if (item.last) begin
      kind = OP_COUNT_LAST;
    end else begin
      kind = OP_COUNT;
    end
  end

  assign q_wdata = {kind, bin};

  he_fifo #(
    .WIDTH (OW),
    .DEPTH (DEPTH)
  ) u_opq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (q_wdata),
    .full  (full),
    .pop   (op_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign op_valid = !q_empty;
  assign op_kind  = op_kind_t'(q_rdata[OW-1 -: KW]);
  assign op_bin   = q_rdata[BB-1:0];

endmodule

`default_nettype wire

// ===== hdl/he_back.sv =====
`default_nettype none

module he_back
  import he_pkg::*;
#(
  parameter int NUM_BINS   = HE_NUM_BINS,
  parameter int COUNT_BITS = HE_COUNT_BITS,
  parameter int FRAC_BITS  = HE_FRAC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        op_valid,
  input  wire op_kind_t                    op_kind,
  input  wire logic [$clog2(NUM_BINS)-1:0] op_bin,
  output logic                             op_pop,
  input  wire logic                        res_full,
  output logic                             res_push,
  output out_item_t                        res_data,
  output logic                             init_done
);

  localparam int BB    = $clog2(NUM_BINS);
  localparam int CW    = COUNT_BITS;
  localparam int SCALE = (NUM_BINS - 1) << FRAC_BITS;
  localparam int QW    = $clog2(SCALE + 1);
  localparam int PW    = CW + BB;
  localparam int NW    = PW + FRAC_BITS;
  localparam int SW    = $clog2(QW);
  localparam int EW    = (QW > HE_OUT_W) ? QW : HE_OUT_W;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT_WR,
    ST_MAP_OUT,
    ST_BLD_RD,
    ST_BLD_ACC,
    ST_BLD_MUL,
    ST_BLD_DIV,
    ST_BLD_WR
  } state_t;

  state_t        state_r, state_nxt;
  logic [BB-1:0] idx_r, idx_nxt;
  logic [BB-1:0] bin_r, bin_nxt;
  logic          last_r, last_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] cum_r, cum_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          in_map_r, in_map_nxt;
  logic          tbl_valid_r, tbl_valid_nxt;
  logic          init_done_r, init_done_nxt;

  logic [CW-1:0] cnt_mem [NUM_BINS];
  logic [CW-1:0] cnt_rd_r;
  logic          cnt_re, cnt_we;
  logic [BB-1:0] cnt_raddr, cnt_waddr;
  logic [CW-1:0] cnt_wdata;

  logic [QW-1:0] tbl_mem [NUM_BINS];
  logic [QW-1:0] tbl_rd_r;
  logic          tbl_re, tbl_we;

  logic [CW:0]   sum;
  logic [PW-1:0] prod;
  logic [NW-1:0] num;
  logic [CW:0]   trial, diff;
  logic          ge;
  logic [EW-1:0] tbl_ext;

  assign tbl_ext   = EW'(tbl_rd_r);
  assign init_done = init_done_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    bin_nxt       = bin_r;
    last_nxt      = last_r;
    total_nxt     = total_r;
    cum_nxt       = cum_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    in_map_nxt    = in_map_r;
    tbl_valid_nxt = tbl_valid_r;
    init_done_nxt = init_done_r;

    op_pop    = 1'b0;
    cnt_re    = 1'b0;
    cnt_raddr = op_bin;
    cnt_we    = 1'b0;
    cnt_waddr = idx_r;
    cnt_wdata = '0;
    tbl_re    = 1'b0;
    tbl_we    = 1'b0;
    res_push  = 1'b0;
    res_data  = '0;

    sum   = {1'b0, cum_r} + {1'b0, cnt_rd_r};
    prod  = PW'(cum_r) * PW'(NUM_BINS - 1);
    num   = NW'(prod) << FRAC_BITS;
    trial = {rem_r, quo_r[QW-1]};
    diff  = trial - {1'b0, total_r};
    ge    = (trial >= {1'b0, total_r});

    unique case (state_r)
      ST_CLEAR: begin
        cnt_we = 1'b1;
        if (idx_r == BB'(NUM_BINS - 1)) begin
          idx_nxt       = '0;
          init_done_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt = idx_r + BB'(1);
        end
      end

      ST_IDLE: begin
        if (op_valid) begin
          unique case (op_kind) inside
            OP_MAP: begin
              if (!res_full) begin
                op_pop     = 1'b1;
                tbl_re     = 1'b1;
                in_map_nxt = 1'b1;
                state_nxt  = ST_MAP_OUT;
              end
            end
            OP_COUNT, OP_COUNT_LAST: begin
              if (in_map_r) begin
                // new frame: wipe the histogram first, keep the word queued
                in_map_nxt = 1'b0;
                total_nxt  = '0;
                idx_nxt    = '0;
                state_nxt  = ST_CLEAR;
              end else begin
                op_pop    = 1'b1;
                cnt_re    = 1'b1;
                bin_nxt   = op_bin;
                last_nxt  = (op_kind == OP_COUNT_LAST);
                state_nxt = ST_CNT_WR;
              end
            end
            default: begin
              op_pop = 1'b1;
            end
          endcase
        end
      end

      ST_CNT_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = bin_r;
        cnt_wdata = (cnt_rd_r == '1) ? cnt_rd_r : cnt_rd_r + CW'(1);
        total_nxt = (total_r == '1) ? total_r : total_r + CW'(1);
        if (last_r) begin
          idx_nxt   = '0;
          cum_nxt   = '0;
          state_nxt = ST_BLD_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_MAP_OUT: begin
        res_push           = 1'b1;
        res_data.no_table  = !tbl_valid_r;
        res_data.equalized = tbl_valid_r ? tbl_ext[HE_OUT_W-1:0] : '0;
        state_nxt          = ST_IDLE;
      end

      ST_BLD_RD: begin
        cnt_re    = 1'b1;
        cnt_raddr = idx_r;
        state_nxt = ST_BLD_ACC;
      end

      ST_BLD_ACC: begin
        // running sum is monotone, so capping each step equals capping the total
        cum_nxt   = (sum >= {1'b0, total_r}) ? total_r : sum[CW-1:0];
        state_nxt = ST_BLD_MUL;
      end

      ST_BLD_MUL: begin
        rem_nxt   = CW'(num >> QW);
        quo_nxt   = num[QW-1:0];
        step_nxt  = SW'(QW - 1);
        state_nxt = ST_BLD_DIV;
      end

      ST_BLD_DIV: begin
        // restoring divide, one quotient bit per cycle
        rem_nxt = ge ? diff[CW-1:0] : trial[CW-1:0];
        quo_nxt = {quo_r[QW-2:0], ge};
        if (step_r == '0) begin
          state_nxt = ST_BLD_WR;
        end else begin
          step_nxt = step_r - SW'(1);
        end
      end

      ST_BLD_WR: begin
        tbl_we = 1'b1;
        if (idx_r == BB'(NUM_BINS - 1)) begin
          idx_nxt       = '0;
          tbl_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + BB'(1);
          state_nxt = ST_BLD_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      last_r      <= 1'b0;
      total_r     <= '0;
      step_r      <= '0;
      in_map_r    <= 1'b0;
      tbl_valid_r <= 1'b0;
      init_done_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      last_r      <= last_nxt;
      total_r     <= total_nxt;
      step_r      <= step_nxt;
      in_map_r    <= in_map_nxt;
      tbl_valid_r <= tbl_valid_nxt;
      init_done_r <= init_done_nxt;
    end
    bin_r <= bin_nxt;
    cum_r <= cum_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd_r <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[idx_r] <= quo_r;
    end
    if (tbl_re) begin
      tbl_rd_r <= tbl_mem[op_bin];
    end
  end

`ifndef NO_ASSERTIONS
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    op_pop |-> (op_valid && state_r == ST_IDLE))
    else $error("op word popped outside idle or from empty queue");

  a_tbl_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(tbl_valid_r))
    else $error("table valid flag dropped");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BLD_DIV |-> rem_r < total_r)
    else $error("divider remainder not below divisor");

  a_build_total: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BLD_RD |-> total_r != '0)
    else $error("table build with zero pixel total");
`endif

endmodule

`default_nettype wire

// ===== hdl/histogram_equalizer.sv =====
`default_nettype none

// Channel   Ports                          Word
// input     in_push, in_full, in_data      in_item_t  {func, luma, last}
// result    out_pop, out_empty, out_data   out_item_t {equalized, no_table}
//
// In the back end a count word does a read-modify-write of the bin memory port;
// a map word reads the table memory and yields one result.
// A count word marked last starts a table build over all NUM_BINS bins, each bin
// read, accumulated, scaled and divided by the one-bit-per-cycle divider to a QW-bit
// value, QW = clog2(((NUM_BINS-1) << FRAC_BITS) + 1). The first count word after map
// words adds a clear of every bin of the bin memory. After reset the same clear runs
// with in_full high. A 4-word queue in front and a 2-word result queue absorb stalls.

module histogram_equalizer
  import he_pkg::*;
#(
  parameter int NUM_BINS   = HE_NUM_BINS,
  parameter int COUNT_BITS = HE_COUNT_BITS,
  parameter int FRAC_BITS  = HE_FRAC_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_push,
  input  wire in_item_t  in_data,
  output logic           in_full,
  input  wire logic      out_pop,
  output out_item_t      out_data,
  output logic           out_empty
);

  localparam int BB = $clog2(NUM_BINS);
  localparam int RW = $bits(out_item_t);

  logic          opq_full;
  logic          op_valid, op_pop;
  op_kind_t      op_kind;
  logic [BB-1:0] op_bin;
  logic          res_full, res_push;
  out_item_t     res_data;
  logic          init_done;
  logic [RW-1:0] res_rdata;

  assign in_full = opq_full || !init_done;

  he_front #(
    .NUM_BINS (NUM_BINS),
    .DEPTH    (HE_OPQ_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push && !in_full),
    .item     (in_data),
    .full     (opq_full),
    .op_valid (op_valid),
    .op_kind  (op_kind),
    .op_bin   (op_bin),
    .op_pop   (op_pop)
  );

  he_back #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op_kind   (op_kind),
    .op_bin    (op_bin),
    .op_pop    (op_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data),
    .init_done (init_done)
  );

  he_fifo #(
    .WIDTH (RW),
    .DEPTH (HE_RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_data = out_item_t'(res_rdata);

endmodule

`default_nettype wire
